@@ sv/wrs_pkg.sv @@
// Shared constants and types for the word reverser stream.
package wrs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] SPACE_CHAR = 8'd32;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       is_space;
  } cmd_t;

endpackage

@@ sv/wrs_front.sv @@
// Front end: accept items, classify them and queue them for the back end.
module wrs_front
  import wrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       end_of_line,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_wr;
  logic       do_rd;
  cmd_t       cmd_in;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_comb begin
    cmd_in.ch       = char_in;
    cmd_in.eol      = end_of_line;
    cmd_in.is_space = (char_in == SPACE_CHAR);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ sv/wrs_back.sv @@
// Back end: word stack, drain sequencer and result register.
module wrs_back
  import wrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out,
  output logic       last_of_run,
  output logic       overflow_seen
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_OUT, S_SPACE} state_t;

  state_t           state;
  logic [7:0]       mem [STACK_DEPTH];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic             dropped;
  logic             run_flag;
  logic             tail_space;
  logic             out_valid;
  logic             out_free;
  logic             stack_full;
  logic             wr_en;

  assign empty      = !out_valid;
  assign out_free   = !out_valid || pop;
  assign cmd_take   = (state == S_IDLE) && cmd_valid;
  assign count_m1   = count - CNT_W'(1);
  assign stack_full = (count == CNT_W'(STACK_DEPTH));
  assign wr_en      = cmd_take && !cmd.is_space && !stack_full;

  // Stack storage: write on push, registered read while draining.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= cmd.ch;
    end
    if (state == S_RD) begin
      rd_data <= mem[count_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      dropped    <= 1'b0;
      run_flag   <= 1'b0;
      tail_space <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            tail_space <= cmd.is_space;
            if (cmd.is_space) begin
              run_flag <= dropped;
              dropped  <= 1'b0;
              state    <= (count != '0) ? S_RD : S_SPACE;
            end else if (!stack_full) begin
              count <= count + CNT_W'(1);
              if (cmd.eol) begin
                run_flag <= dropped;
                dropped  <= 1'b0;
                state    <= S_RD;
              end
            end else if (cmd.eol) begin
              run_flag <= 1'b1;
              dropped  <= 1'b0;
              state    <= S_RD;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_RD: begin
          count <= count_m1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            char_out      <= rd_data;
            last_of_run   <= (count == '0) && !tail_space;
            overflow_seen <= run_flag;
            if (count != '0) begin
              state <= S_RD;
            end else if (tail_space) begin
              state <= S_SPACE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SPACE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            char_out      <= SPACE_CHAR;
            last_of_run   <= 1'b1;
            overflow_seen <= run_flag;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack fill count above depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (count != '0))
    else $error("stack read issued with empty stack");

  a_run_flag_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state) != S_IDLE) |-> $stable(run_flag))
    else $error("overflow flag changed inside a run");

  a_space_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPACE && out_free) |=> (state == S_IDLE && out_valid && last_of_run))
    else $error("space result did not close the run");

endmodule

@@ sv/word_reverser_stream.sv @@
// Top level of the word reverser stream: front end, command queue and back end.
//
// Usage:
//   Input side is a queue: drive char_in and end_of_line, raise push; the item
//   is taken at a clock edge where push is high and full is low.
//   Result side is a queue: while empty is low, char_out, last_of_run and
//   overflow_seen show the oldest result; raise pop to take it.
//   A non-space item is stored on the word stack and yields no result.
//   A space drains the stack (last letter first) and then emits the space.
//   end_of_line drains the stack after a non-space item's character, with no
//   trailing space. last_of_run marks the final result of an item, and
//   overflow_seen reports characters dropped on a full stack since the last run.
// Flow:
//   A two-entry command queue sits between front and back. Each drained
//   letter passes through the single registered stack read, then a load of the
//   result register; the trailing space is then loaded on its own. The back end
//   takes no new item until a drain has loaded its last result.
// Reset (rst, synchronous): empties queue, stack, flag and result register.
// Stall: a result waits in its register until popped; the back end holds,
//   the command queue fills and full rises.
module word_reverser_stream
  import wrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out,
  output logic       last_of_run,
  output logic       overflow_seen
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // Classify and queue incoming items.
  wrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_in     (char_in),
    .end_of_line (end_of_line),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // Execute commands against the word stack and emit results.
  wrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .empty         (empty),
    .pop           (pop),
    .char_out      (char_out),
    .last_of_run   (last_of_run),
    .overflow_seen (overflow_seen)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for word_reverser_stream: random lines in, reversed words checked out.
`timescale 1ns / 100ps

module testbench
  import wrs_pkg::*;
();

  localparam int RANDOM_ITEMS   = 420;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 30;

  // One result item as the block shows it on its output side.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } reversed_char_t;

  // Scoreboard: tracks the word stack on its own and queues the characters
  // that each accepted item must bring out, then checks them in order.
  class word_reverse_board;
    logic [7:0]       letters [STACK_DEPTH];
    logic [CNT_W-1:0] fill;
    logic             dropped;
    reversed_char_t   batch [$];
    reversed_char_t   pending_chars [$];
    int               errors;

    function new();
      fill    = '0;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    // Pop the whole word, last letter first, onto the current batch.
    function void unwind_word();
      while (fill > 0) begin
        fill--;
        batch.push_back('{letters[fill[ADDR_W-1:0]], 1'b0, 1'b0});
      end
    endfunction

    // Note one accepted item; return 1 if its character hit a full stack.
    function bit note_item(logic [7:0] c, logic eol);
      bit hit_full;
      hit_full = 1'b0;
      batch.delete();
      if (c == SPACE_CHAR) begin
        unwind_word();
        batch.push_back('{SPACE_CHAR, 1'b0, 1'b0});
      end else if (fill < STACK_DEPTH) begin
        letters[fill[ADDR_W-1:0]] = c;
        fill++;
      end else begin
        dropped  = 1'b1;
        hit_full = 1'b1;
      end
      if (eol)
        unwind_word();
      // The sticky drop flag rides on every character of the run, then clears.
      if (batch.size() > 0) begin
        foreach (batch[i])
          batch[i].ovf = dropped;
        batch[batch.size()-1].last = 1'b1;
        dropped = 1'b0;
        foreach (batch[i])
          pending_chars.push_back(batch[i]);
      end
      return hit_full;
    endfunction

    function void check_result(logic [7:0] ch, logic last, logic ovf);
      reversed_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: char_out=%0d last_of_run=%0b overflow_seen=%0b",
               ch, last, ovf);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (ch !== want.ch) begin
          $error("char_out: expected %0d, actual %0d", want.ch, ch);
          errors++;
        end
        if (last !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, last);
          errors++;
        end
        if (ovf !== want.ovf) begin
          $error("overflow_seen: expected %0b, actual %0b", want.ovf, ovf);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_in = 8'd0;
  logic       end_of_line = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] char_out;
  logic       last_of_run;
  logic       overflow_seen;

  word_reverse_board board;
  bit  no_idle = 1'b0;     // set for stretches with back-to-back traffic
  int  items_done = 0;     // accepted items that were not dropped
  int  pop_hold = 0;
  int  quiet_cycles = 0;

  word_reverser_stream dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_in      (char_in),
    .end_of_line  (end_of_line),
    .empty        (empty),
    .pop          (pop),
    .char_out     (char_out),
    .last_of_run  (last_of_run),
    .overflow_seen(overflow_seen)
  );

  always #6 clk = ~clk;

  // Gap length for either side: mostly none or short, a few long.
  function automatic int idle_length();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // Push stays high on return so a following item can go out back to back.
  task automatic send_item(input logic [7:0] c, input logic eol);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    char_in     <= c;
    end_of_line <= eol;
    @(posedge clk);
    while (full)
      @(posedge clk);
    if (!board.note_item(c, eol))
      items_done++;
  endtask

  // Stop sending until the block has handed out everything owed so far.
  task automatic wait_all_out();
    push <= 1'b0;
    @(posedge clk);
    while (board.outstanding() > 0)
      @(posedge clk);
  endtask

  // Result side: check each popped item, drive pop with random stalls, and
  // watch for a stuck handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty)
        board.check_result(char_out, last_of_run, overflow_seen);
      if ((push && !full) || (pop && !empty))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
        pop_hold = idle_length();
      end
    end
  end

  initial begin
    int         nwords;
    int         len;
    bit         last_word;
    bit         eol_on_space;
    logic [7:0] c;

    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: space on an empty stack, alone and with end of line.
    send_item(SPACE_CHAR, 1'b0);
    send_item(SPACE_CHAR, 1'b1);
    // A short word closed by a space.
    send_item(8'h68, 1'b0);
    send_item(8'h69, 1'b0);
    send_item(SPACE_CHAR, 1'b0);
    // Byte extremes, flushed by end of line on the last letter.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b1);
    // Space carrying end of line: the space comes out last.
    send_item(8'h78, 1'b0);
    send_item(SPACE_CHAR, 1'b1);
    // One-letter line.
    send_item(8'h71, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(SPACE_CHAR, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
    wait_all_out();

    // Random lines of words; now and then a word long enough to overrun
    // the stack, plus some stray bytes between words.
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 99) < 15);
      nwords  = $urandom_range(1, 6);
      for (int w = 0; w < nwords; w++) begin
        if ($urandom_range(0, 99) < 15)
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        len          = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 38)
                                                   : $urandom_range(0, 8);
        last_word    = (w == nwords - 1);
        eol_on_space = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          do
            c = 8'($urandom_range(0, 255));
          while (c == SPACE_CHAR);
          send_item(c, last_word && !eol_on_space && (i == len - 1));
        end
        if (!last_word || eol_on_space || len == 0)
          send_item(SPACE_CHAR, last_word);
      end
      if ($urandom_range(0, 19) == 0)
        wait_all_out();
    end

    // Drain: stop sending, wait out every owed result, then let the pipe settle.
    no_idle = 1'b0;
    wait_all_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ word_reverser_stream.f @@
sv/wrs_pkg.sv
sv/wrs_front.sv
sv/wrs_back.sv
sv/word_reverser_stream.sv
bench/testbench.sv
